>>> hw/rtl/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared widths, register indexes and transfer types of the radial
// vignetting correction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC        = 20;
  localparam int COEF_W      = 24;
  localparam int X_W         = 32;
  localparam int R2_W        = 40;
  localparam int H_W         = 41;
  localparam int ACC_W       = 2 * H_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_K1    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K2    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K3    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd4;

  localparam logic [COEF_W-1:0] SCALE_RESET = 24'h100000;

  typedef struct packed {
    logic                          start;
    logic signed [H_W-1:0]         op_a;
    logic signed [H_W-1:0]         op_b;
    logic signed [ACC_W-1:0]       init;
  } rvc_mac_req_t;

  typedef struct packed {
    logic signed [H_W-1:0]   divisor;
    logic [SAMPLE_BITS-1:0]  smp_a;
    logic [SAMPLE_BITS-1:0]  smp_b;
    logic [SAMPLE_BITS-1:0]  smp_c;
    logic [SAMPLE_BITS-1:0]  smp_d;
  } rvc_job_t;

endpackage

`default_nettype wire

>>> hw/rtl/rvc_mac.sv
// ----------------------------------------------------------------------------
// rvc_mac
// Bit-serial signed multiply-accumulate: acc = init + a * b, one bit of b
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rvc_pkg::rvc_mac_req_t              req_i,
  output logic                               done_o,
  output logic signed [rvc_pkg::ACC_W-1:0]   acc_o
);
  import rvc_pkg::*;

  localparam int CNT_W = $clog2(H_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(H_W - 1);

  logic signed [ACC_W-1:0] acc_q, a_q, addend;
  logic [H_W-1:0]          b_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, done_q;

  assign addend = b_q[0] ? a_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.init;
      a_q   <= {{(ACC_W-H_W){req_i.op_a[H_W-1]}}, req_i.op_a};
      b_q   <= req_i.op_b;
    end else if (busy_q) begin
      // top bit of b carries negative weight
      acc_q <= (cnt_q == LAST) ? acc_q - addend : acc_q + addend;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/rvc_front.sv
// ----------------------------------------------------------------------------
// rvc_front
// Accepts pixels, keeps the running coordinate and squared radius, and
// evaluates the divisor polynomial on the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rvc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [rvc_pkg::COEF_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  row_start_i,
  input  logic signed [rvc_pkg::COEF_W-1:0]     start_x_i,
  input  logic signed [rvc_pkg::COEF_W-1:0]     start_y_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_a_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_b_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_c_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_d_i,
  output logic                                  push_o,
  output rvc_pkg::rvc_job_t                     job_o,
  input  logic                                  full_i
);
  import rvc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SX   = 4'd1;
  localparam logic [3:0] ST_SY   = 4'd2;
  localparam logic [3:0] ST_XX   = 4'd3;
  localparam logic [3:0] ST_YY   = 4'd4;
  localparam logic [3:0] ST_H1   = 4'd5;
  localparam logic [3:0] ST_H2   = 4'd6;
  localparam logic [3:0] ST_H3   = 4'd7;
  localparam logic [3:0] ST_PUSH = 4'd8;
  localparam logic [3:0] ST_ADV  = 4'd9;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] HMAX = (ACC_W'(1) << (H_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HMIN = -HMAX;
  localparam logic signed [ACC_W-1:0] ONE_C = ACC_W'(1) << (2 * FRAC);

  logic [3:0]                 state_q, state_d;
  logic                       phase_q;
  logic signed [COEF_W-1:0]   k1_q, k2_q, k3_q, step_q;
  logic [COEF_W-1:0]          scale_q;
  logic signed [COEF_W-1:0]   sx_q, sy_q;
  logic signed [X_W-1:0]      cur_x_q, y_q;
  logic signed [R2_W-1:0]     r2_q;
  logic signed [H_W-1:0]      h_q, c_q;
  logic [SAMPLE_BITS-1:0]     sa_q, sb_q, sc_q, sd_q;

  rvc_mac_req_t               mac_req;
  logic                       mac_done, is_mul;
  logic signed [ACC_W-1:0]    mac_acc, rnd_full, rnd_in;
  logic signed [H_W-1:0]      rnd_sat;
  logic signed [X_W+1:0]      step2x;

  rvc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  assign rnd_in   = mac_acc + HALF;
  assign rnd_full = rnd_in >>> FRAC;

  always_comb begin
    priority if (rnd_full > HMAX) rnd_sat = HMAX[H_W-1:0];
    else if (rnd_full < HMIN)     rnd_sat = HMIN[H_W-1:0];
    else                          rnd_sat = rnd_full[H_W-1:0];
  end

  assign step2x = {cur_x_q[X_W-1], cur_x_q, 1'b0}
                + {{(X_W+2-COEF_W){step_q[COEF_W-1]}}, step_q};

  assign is_mul = (state_q != ST_IDLE) && (state_q != ST_PUSH);

  always_comb begin
    mac_req       = '0;
    mac_req.start = is_mul && !phase_q;
    unique case (state_q)
      ST_SX: begin
        mac_req.op_a = H_W'(sx_q);
        mac_req.op_b = {{(H_W-COEF_W){1'b0}}, scale_q};
      end
      ST_SY: begin
        mac_req.op_a = H_W'(sy_q);
        mac_req.op_b = {{(H_W-COEF_W){1'b0}}, scale_q};
      end
      ST_XX: begin
        mac_req.op_a = H_W'(cur_x_q);
        mac_req.op_b = H_W'(cur_x_q);
      end
      ST_YY: begin
        mac_req.op_a = H_W'(y_q);
        mac_req.op_b = H_W'(y_q);
        mac_req.init = mac_acc;
      end
      ST_H1: begin
        mac_req.op_a = H_W'(r2_q);
        mac_req.op_b = H_W'(k3_q);
        mac_req.init = ACC_W'(k2_q) <<< FRAC;
      end
      ST_H2: begin
        mac_req.op_a = H_W'(r2_q);
        mac_req.op_b = h_q;
        mac_req.init = ACC_W'(k1_q) <<< FRAC;
      end
      ST_H3: begin
        mac_req.op_a = H_W'(r2_q);
        mac_req.op_b = h_q;
        mac_req.init = ONE_C;
      end
      ST_ADV: begin
        // step^2 + 2*step*x as step * (step + 2x)
        mac_req.op_a = H_W'(step_q);
        mac_req.op_b = H_W'(step2x);
        mac_req.init = ACC_W'(r2_q) <<< FRAC;
      end
      default: begin
        mac_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = row_start_i ? ST_SX : ST_H1;
      ST_SX:   if (phase_q && mac_done) state_d = ST_SY;
      ST_SY:   if (phase_q && mac_done) state_d = ST_XX;
      ST_XX:   if (phase_q && mac_done) state_d = ST_YY;
      ST_YY:   if (phase_q && mac_done) state_d = ST_H1;
      ST_H1:   if (phase_q && mac_done) state_d = ST_H2;
      ST_H2:   if (phase_q && mac_done) state_d = ST_H3;
      ST_H3:   if (phase_q && mac_done) state_d = ST_PUSH;
      ST_PUSH: if (!full_i) state_d = ST_ADV;
      ST_ADV:  if (phase_q && mac_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      k1_q    <= '0;
      k2_q    <= '0;
      k3_q    <= '0;
      step_q  <= '0;
      scale_q <= SCALE_RESET;
      cur_x_q <= '0;
      r2_q    <= '0;
    end else begin
      state_q <= state_d;
      if (mac_req.start) begin
        phase_q <= 1'b1;
      end else if (mac_done) begin
        phase_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_K1:    k1_q    <= cfg_data_i;
          CFG_K2:    k2_q    <= cfg_data_i;
          CFG_K3:    k3_q    <= cfg_data_i;
          CFG_STEP:  step_q  <= cfg_data_i;
          CFG_SCALE: scale_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (phase_q && mac_done) begin
        unique case (state_q)
          ST_SX:  cur_x_q <= rnd_full[X_W-1:0];
          ST_YY:  r2_q    <= rnd_full[R2_W-1:0];
          ST_ADV: begin
            r2_q    <= rnd_full[R2_W-1:0];
            cur_x_q <= cur_x_q + X_W'(step_q);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      sa_q <= sample_a_i;
      sb_q <= sample_b_i;
      sc_q <= sample_c_i;
      sd_q <= sample_d_i;
    end
    if (phase_q && mac_done) begin
      unique case (state_q)
        ST_SY:   y_q <= rnd_full[X_W-1:0];
        ST_H1,
        ST_H2:   h_q <= rnd_sat;
        ST_H3:   c_q <= rnd_sat;
        default: ;
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign push_o        = (state_q == ST_PUSH) && !full_i;
  assign job_o.divisor = c_q;
  assign job_o.smp_a   = sa_q;
  assign job_o.smp_b   = sb_q;
  assign job_o.smp_c   = sc_q;
  assign job_o.smp_d   = sd_q;

endmodule

`default_nettype wire

>>> hw/rtl/rvc_fifo.sv
// ----------------------------------------------------------------------------
// rvc_fifo
// Two-entry queue of divisor jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rvc_pkg::rvc_job_t  data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rvc_pkg::rvc_job_t  data_o
);
  import rvc_pkg::*;

  rvc_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

>>> hw/rtl/rvc_back.sv
// ----------------------------------------------------------------------------
// rvc_back
// Four restoring dividers, one quotient bit per cycle each, with clamping,
// saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  rvc_pkg::rvc_job_t                   job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]     result_a_o,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]     result_b_o,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]     result_c_o,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]     result_d_o,
  output logic                                saturated_o
);
  import rvc_pkg::*;

  localparam int NUM_W = ((SAMPLE_BITS + FRAC > H_W - 2) ? SAMPLE_BITS + FRAC : H_W - 2) + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]             state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [H_W-1:0]         c_q;
  logic                   nonpos_q, out_valid_q, load_out;
  logic [NUM_W-1:0]       num_q  [4];
  logic [H_W-1:0]         rem_q  [4];
  logic [H_W:0]           trial  [4];
  logic                   fit    [4];
  logic [SAMPLE_BITS-1:0] pix    [4];
  logic [SAMPLE_BITS-1:0] res    [4];
  logic [3:0]             hi;
  logic [SAMPLE_BITS-1:0] res_q  [4];
  logic                   sat_q;

  assign pix[0] = job_i.smp_a;
  assign pix[1] = job_i.smp_b;
  assign pix[2] = job_i.smp_c;
  assign pix[3] = job_i.smp_d;

  assign pop_o    = (state_q == B_IDLE) && valid_i;
  assign load_out = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i] = {rem_q[i], num_q[i][NUM_W-1]};
      fit[i]   = (trial[i] >= {1'b0, c_q});
      hi[i]    = |num_q[i][NUM_W-1:SAMPLE_BITS];
      if (nonpos_q) begin
        res[i] = '0;
      end else if (hi[i]) begin
        res[i] = '1;
      end else begin
        res[i] = num_q[i][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (valid_i) begin
          cnt_q   <= '0;
          // non-positive divisor skips the division
          state_q <= (job_i.divisor[H_W-1] || job_i.divisor == '0) ? B_DONE : B_DIV;
        end
        B_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) state_q <= B_DONE;
        end
        B_DONE: if (load_out) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      c_q      <= job_i.divisor;
      nonpos_q <= job_i.divisor[H_W-1] || (job_i.divisor == '0);
      for (int i = 0; i < 4; i++) begin
        num_q[i] <= NUM_W'({pix[i], {FRAC{1'b0}}}) + NUM_W'(job_i.divisor[H_W-1:1]);
        rem_q[i] <= '0;
      end
    end else if (state_q == B_DIV) begin
      for (int i = 0; i < 4; i++) begin
        rem_q[i] <= fit[i] ? H_W'(trial[i] - {1'b0, c_q}) : trial[i][H_W-1:0];
        num_q[i] <= {num_q[i][NUM_W-2:0], fit[i]};
      end
    end
    if (load_out) begin
      for (int i = 0; i < 4; i++) res_q[i] <= res[i];
      sat_q <= nonpos_q || (|hi);
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_a_o  = res_q[0];
  assign result_b_o  = res_q[1];
  assign result_c_o  = res_q[2];
  assign result_d_o  = res_q[3];
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

>>> hw/rtl/radial_vignetting_correction_unit.sv
// ----------------------------------------------------------------------------
// radial_vignetting_correction_unit
// Divides each four-component pixel by 1 + k1*r2 + k2*r2^2 + k3*r2^3.
// ----------------------------------------------------------------------------
// The front end handles one pixel at a time on a single bit-serial multiplier:
// four products per pixel, and four more on the first pixel of a row for the
// start coordinates. The back end divides the four components in parallel and
// runs behind a two-entry queue, so it overlaps the next pixel's front-end work.
// Registers are written through cfg_we_i; the user must write them only while
// no pixel is in flight, as the block itself does not enforce this.
`default_nettype none

module radial_vignetting_correction_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rvc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [rvc_pkg::COEF_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  row_start_i,
  input  logic signed [rvc_pkg::COEF_W-1:0]     start_x_i,
  input  logic signed [rvc_pkg::COEF_W-1:0]     start_y_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_a_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_b_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_c_i,
  input  logic [rvc_pkg::SAMPLE_BITS-1:0]       sample_d_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]       result_a_o,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]       result_b_o,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]       result_c_o,
  output logic [rvc_pkg::SAMPLE_BITS-1:0]       result_d_o,
  output logic                                  saturated_o
);
  import rvc_pkg::*;

  rvc_job_t job_in, job_out;
  logic     push, full, pop, q_valid;

  rvc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .row_start_i (row_start_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .sample_a_i  (sample_a_i),
    .sample_b_i  (sample_b_i),
    .sample_c_i  (sample_c_i),
    .sample_d_i  (sample_d_i),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  rvc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  rvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_a_o  (result_a_o),
    .result_b_o  (result_b_o),
    .result_c_o  (result_c_o),
    .result_d_o  (result_d_o),
    .saturated_o (saturated_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue read while empty");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("front end took a second item while busy");

endmodule

`default_nettype wire
